/* rtl/gm2j_pkg.sv */
// ----------------------------------------------------------------------------
// Gaussian 2D model and Jacobian: shared package
// Constants, register codes and small helper functions used across the block.
// ----------------------------------------------------------------------------
package gm2j_pkg;

  // Default number of fraction bits of the external fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Configuration register codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_SIGMA_X   = 3'd2,
    REG_SIGMA_Y   = 3'd3,
    REG_AMPLITUDE = 3'd4,
    REG_OFFSET    = 3'd5
  } cfg_reg_t;

  // Internal fixed-point constants.
  localparam logic [23:0] LN2_Q24   = 24'd11629080;
  localparam logic [8:0]  LN2_RECIP = 9'd369;           // floor(2^32 / ln2_q24)
  localparam logic [30:0] T_CUT     = 31'(22) << 24;
  localparam logic [27:0] U_CAP     = 28'(1) << 27;
  localparam logic [31:0] G_CAP     = 32'h8000_0000;
  localparam logic [30:0] ONE_Q30   = 31'(1) << 30;

  // Reciprocal floor((2^32 - 1) / k) for the Horner divisions.
  function automatic logic [31:0] recip_const(input int k);
    logic [31:0] m;
    unique case (k)
      1:       m = 32'd4294967295;
      2:       m = 32'd2147483647;
      3:       m = 32'd1431655765;
      4:       m = 32'd1073741823;
      5:       m = 32'd858993459;
      6:       m = 32'd715827882;
      7:       m = 32'd613566756;
      8:       m = 32'd536870911;
      9:       m = 32'd477218588;
      10:      m = 32'd429496729;
      default: m = 32'd390451572;
    endcase
    return m;
  endfunction

  // Apply a sign to a magnitude and saturate to the signed 32-bit range.
  function automatic logic [31:0] sat_mag(input logic neg, input logic ovf,
                                          input logic [31:0] mag);
    logic [31:0] res;
    if (neg) begin
      res = (ovf || mag[31]) ? 32'h8000_0000 : (~mag + 32'd1);
    end else begin
      res = (ovf || mag[31]) ? 32'h7FFF_FFFF : mag;
    end
    return res;
  endfunction

endpackage

/* rtl/gaussian_2d_model_jacobian.sv */
// ----------------------------------------------------------------------------
// Gaussian 2D model and Jacobian row
// Evaluates an axis-aligned 2D Gaussian and its negated parameter derivatives.
// ----------------------------------------------------------------------------
// The block takes one sample point per clock cycle while the result side does
// not stall and returns one result per point, in order. The latency is set by
// the two bit-per-stage dividers (the normalised distance and the derivative
// scaling) and by the eleven three-stage Horner steps of the exponential. A
// stall on the result side holds the whole pipeline, so the input stalls in
// the same cycle. Registers are written through the configuration channel,
// which is always ready; write them only while no point is in flight.
module gaussian_2d_model_jacobian #(
  parameter int FRAC_BITS = gm2j_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gm2j_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] model_value,
  output logic signed [31:0] neg_d_center_x,
  output logic signed [31:0] neg_d_center_y,
  output logic signed [31:0] neg_d_sigma_x,
  output logic signed [31:0] neg_d_sigma_y,
  output logic signed [31:0] neg_d_amplitude
);

  localparam int DSH   = 30 - FRAC_BITS;
  localparam int DEN_W = 31 + DSH;

  // Configuration registers.
  logic [31:0] center_x, center_y, amplitude, offset;
  logic [30:0] sigma_x, sigma_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= '0;
      center_y  <= '0;
      sigma_x   <= 31'(1) << FRAC_BITS;
      sigma_y   <= 31'(1) << FRAC_BITS;
      amplitude <= 32'(1) << FRAC_BITS;
      offset    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gm2j_pkg::REG_CENTER_X:  center_x  <= cfg_data;
        gm2j_pkg::REG_CENTER_Y:  center_y  <= cfg_data;
        gm2j_pkg::REG_SIGMA_X:   sigma_x   <= cfg_data[30:0];
        gm2j_pkg::REG_SIGMA_Y:   sigma_y   <= cfg_data[30:0];
        gm2j_pkg::REG_AMPLITUDE: amplitude <= cfg_data;
        gm2j_pkg::REG_OFFSET:    offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Values derived from configuration; the block relies on the user to keep them stable while points are in flight.
  logic [30:0]      sx, sy;
  logic             a_neg;
  logic [31:0]      a_mag;
  logic [DEN_W-1:0] den_x, den_y;

  assign sx    = (sigma_x == 31'd0) ? 31'd1 : sigma_x;
  assign sy    = (sigma_y == 31'd0) ? 31'd1 : sigma_y;
  assign a_neg = amplitude[31];
  assign a_mag = a_neg ? (~amplitude + 32'd1) : amplitude;
  assign den_x = DEN_W'(sx) << DSH;
  assign den_y = DEN_W'(sy) << DSH;

  // The whole pipeline advances unless a finished result is held up.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: distance from the centre as sign and magnitude.
  logic [32:0] dx, dy;
  logic        s1_v, s1_xn, s1_yn;
  logic [32:0] s1_magx, s1_magy;

  assign dx = {x_coord[31], x_coord} - {center_x[31], center_x};
  assign dy = {y_coord[31], y_coord} - {center_y[31], center_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xn   <= dx[32];
      s1_yn   <= dy[32];
      s1_magx <= dx[32] ? (~dx + 33'd1) : dx;
      s1_magy <= dy[32] ? (~dy + 33'd1) : dy;
    end
  end

  // Normalised distance |d| / sigma in Q24, rounded.
  logic [56:0] num_x, num_y;
  logic        rx_v, ry_v, rx_ovf, ry_ovf, rx_n, ry_n;
  logic [27:0] rx_q, ry_q;

  assign num_x = (57'(s1_magx) << 24) + 57'(sx >> 1);
  assign num_y = (57'(s1_magy) << 24) + 57'(sy >> 1);

  gm2j_div #(.NW(57), .DW(31), .QB(28), .SW(1)) u_ratio_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(s1_v), .num(num_x), .den(sx),
    .side_in(s1_xn), .out_valid(rx_v), .quo(rx_q), .ovf(rx_ovf), .side_out(rx_n)
  );

  gm2j_div #(.NW(57), .DW(31), .QB(28), .SW(1)) u_ratio_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(s1_v), .num(num_y), .den(sy),
    .side_in(s1_yn), .out_valid(ry_v), .quo(ry_q), .ovf(ry_ovf), .side_out(ry_n)
  );

  // Stage 2: clamp the ratios to 8.0.
  logic        s2_v, s2_xn, s2_yn;
  logic [27:0] s2_qx, s2_qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= rx_v && ry_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_qx <= (rx_ovf || rx_q > gm2j_pkg::U_CAP) ? gm2j_pkg::U_CAP : rx_q;
      s2_qy <= (ry_ovf || ry_q > gm2j_pkg::U_CAP) ? gm2j_pkg::U_CAP : ry_q;
      s2_xn <= rx_n;
      s2_yn <= ry_n;
    end
  end

  // Stage 3: squares.  Stage 4: half their sum, rounded.
  logic        s3_v, s3_xn, s3_yn, s4_v, s4_xn, s4_yn;
  logic [27:0] s3_qx, s3_qy, s4_qx, s4_qy;
  logic [55:0] s3_sqx, s3_sqy;
  logic [56:0] sq_sum;
  logic [30:0] s4_t;

  assign sq_sum = 57'(s3_sqx) + 57'(s3_sqy) + (57'(1) << 24);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sqx <= 56'(s2_qx) * 56'(s2_qx);
      s3_sqy <= 56'(s2_qy) * 56'(s2_qy);
      s3_qx  <= s2_qx;
      s3_qy  <= s2_qy;
      s3_xn  <= s2_xn;
      s3_yn  <= s2_yn;
      s4_t   <= 31'(sq_sum >> 25);
      s4_qx  <= s3_qx;
      s4_qy  <= s3_qy;
      s4_xn  <= s3_xn;
      s4_yn  <= s3_yn;
    end
  end

  // Exponential term.
  logic        ex_v;
  logic [30:0] ex_e;
  logic [57:0] ex_side;
  logic [27:0] ex_qx, ex_qy;
  logic        ex_xn, ex_yn;

  gm2j_exp #(.SW(58)) u_exp (
    .clk(clk), .rst(rst), .en(en), .in_valid(s4_v), .t_in(s4_t),
    .side_in({s4_qx, s4_qy, s4_xn, s4_yn}),
    .out_valid(ex_v), .e_out(ex_e), .side_out(ex_side)
  );

  assign {ex_qx, ex_qy, ex_xn, ex_yn} = ex_side;

  // Stage 5: E*u, E*v and A*E.
  logic        s5_v, s5_xn, s5_yn;
  logic [27:0] s5_qx, s5_qy;
  logic [30:0] s5_e;
  logic [31:0] s5_gx, s5_gy;
  logic [62:0] s5_ae;
  logic [58:0] gx_p, gy_p;

  assign gx_p = 59'(ex_e) * 59'(ex_qx);
  assign gy_p = 59'(ex_e) * 59'(ex_qy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= ex_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_gx <= (gx_p[58:24] > 35'(gm2j_pkg::G_CAP)) ? gm2j_pkg::G_CAP : gx_p[55:24];
      s5_gy <= (gy_p[58:24] > 35'(gm2j_pkg::G_CAP)) ? gm2j_pkg::G_CAP : gy_p[55:24];
      s5_ae <= 63'(a_mag) * 63'(ex_e);
      s5_e  <= ex_e;
      s5_qx <= ex_qx;
      s5_qy <= ex_qy;
      s5_xn <= ex_xn;
      s5_yn <= ex_yn;
    end
  end

  // Stage 6: E*u^2, E*v^2, the model value and the amplitude derivative.
  logic        s6_v, s6_xn, s6_yn;
  logic [31:0] s6_gx, s6_gy, s6_gxx, s6_gyy, s6_model, s6_nda;
  logic [59:0] gxx_p, gyy_p;
  logic [32:0] ae;
  logic [34:0] model_sum;
  logic [30:0] e_rnd;

  assign gxx_p     = 60'(s5_gx) * 60'(s5_qx);
  assign gyy_p     = 60'(s5_gy) * 60'(s5_qy);
  assign ae        = 33'((s5_ae + (63'(1) << 29)) >> 30);
  assign model_sum = (a_neg ? (~35'(ae) + 35'd1) : 35'(ae))
                   + {{3{offset[31]}}, offset};
  assign e_rnd     = (s5_e + (31'(1) << (DSH - 1))) >> DSH;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_gx  <= s5_gx;
      s6_gy  <= s5_gy;
      s6_gxx <= (gxx_p[59:24] > 36'(gm2j_pkg::G_CAP)) ? gm2j_pkg::G_CAP : gxx_p[55:24];
      s6_gyy <= (gyy_p[59:24] > 36'(gm2j_pkg::G_CAP)) ? gm2j_pkg::G_CAP : gyy_p[55:24];
      s6_xn  <= s5_xn;
      s6_yn  <= s5_yn;
      s6_nda <= ~32'(e_rnd) + 32'd1;
      // Saturate the model value to the signed 32-bit range.
      if (!model_sum[34] && (model_sum[33:31] != 3'b000)) begin
        s6_model <= 32'h7FFF_FFFF;
      end else if (model_sum[34] && (model_sum[33:31] != 3'b111)) begin
        s6_model <= 32'h8000_0000;
      end else begin
        s6_model <= model_sum[31:0];
      end
    end
  end

  // Stage 7: |A| times each derivative term.
  logic        s7_v, s7_xn, s7_yn;
  logic [31:0] s7_model, s7_nda;
  logic [62:0] s7_px, s7_py, s7_pxx, s7_pyy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_px    <= 63'(a_mag) * 63'(s6_gx);
      s7_py    <= 63'(a_mag) * 63'(s6_gy);
      s7_pxx   <= 63'(a_mag) * 63'(s6_gxx);
      s7_pyy   <= 63'(a_mag) * 63'(s6_gyy);
      s7_model <= s6_model;
      s7_nda   <= s6_nda;
      s7_xn    <= s6_xn;
      s7_yn    <= s6_yn;
    end
  end

  // Scaling by sigma, rounded to nearest.
  logic [62:0] half_x, half_y;
  logic        dvx_v, dvy_v, dvxx_v, dvyy_v;
  logic        dvx_o, dvy_o, dvxx_o, dvyy_o;
  logic [31:0] dvx_q, dvy_q, dvxx_q, dvyy_q;
  logic [31:0] dv_model, dv_nda;
  logic        dv_xn, dv_yn;

  assign half_x = 63'(den_x >> 1);
  assign half_y = 63'(den_y >> 1);

  gm2j_div #(.NW(63), .DW(DEN_W), .QB(32), .SW(32)) u_scale_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(s7_v), .num(s7_px + half_x),
    .den(den_x), .side_in(s7_model), .out_valid(dvx_v), .quo(dvx_q),
    .ovf(dvx_o), .side_out(dv_model)
  );

  gm2j_div #(.NW(63), .DW(DEN_W), .QB(32), .SW(32)) u_scale_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(s7_v), .num(s7_py + half_y),
    .den(den_y), .side_in(s7_nda), .out_valid(dvy_v), .quo(dvy_q),
    .ovf(dvy_o), .side_out(dv_nda)
  );

  gm2j_div #(.NW(63), .DW(DEN_W), .QB(32), .SW(1)) u_scale_xx (
    .clk(clk), .rst(rst), .en(en), .in_valid(s7_v), .num(s7_pxx + half_x),
    .den(den_x), .side_in(s7_xn), .out_valid(dvxx_v), .quo(dvxx_q),
    .ovf(dvxx_o), .side_out(dv_xn)
  );

  gm2j_div #(.NW(63), .DW(DEN_W), .QB(32), .SW(1)) u_scale_yy (
    .clk(clk), .rst(rst), .en(en), .in_valid(s7_v), .num(s7_pyy + half_y),
    .den(den_y), .side_in(s7_yn), .out_valid(dvyy_v), .quo(dvyy_q),
    .ovf(dvyy_o), .side_out(dv_yn)
  );

  // Output register: signs and saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvx_v && dvy_v && dvxx_v && dvyy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      model_value     <= dv_model;
      neg_d_center_x  <= gm2j_pkg::sat_mag(a_neg == dv_xn, dvx_o, dvx_q);
      neg_d_center_y  <= gm2j_pkg::sat_mag(a_neg == dv_yn, dvy_o, dvy_q);
      neg_d_sigma_x   <= gm2j_pkg::sat_mag(!a_neg, dvxx_o, dvxx_q);
      neg_d_sigma_y   <= gm2j_pkg::sat_mag(!a_neg, dvyy_o, dvyy_q);
      neg_d_amplitude <= dv_nda;
    end
  end

  // Checks.
  a_ratio_aligned: assert property (@(posedge clk) disable iff (rst)
    rx_v == ry_v)
    else $error("ratio dividers out of step");

  a_scale_aligned: assert property (@(posedge clk) disable iff (rst)
    (dvx_v == dvy_v) && (dvx_v == dvxx_v) && (dvx_v == dvyy_v))
    else $error("scaling dividers out of step");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_nda_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (neg_d_amplitude[31] || (neg_d_amplitude == 32'sd0)))
    else $error("amplitude derivative is positive");

endmodule

/* rtl/gm2j_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, overflow check in the first stage. The divisor
// is from configuration; the user keeps it stable while items are in flight.
// ----------------------------------------------------------------------------
module gm2j_div #(
  parameter int NW = 57,
  parameter int DW = 31,
  parameter int QB = 28,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QB-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  logic          vld    [QB+1];
  logic [DW-1:0] rem    [QB+1];
  logic [QB-1:0] low    [QB+1];
  logic [QB-1:0] quo_s  [QB+1];
  logic          ovf_s  [QB+1];
  logic [SW-1:0] side_s [QB+1];

  assign hi_ext  = CW'(num[NW-1:QB]);
  assign den_ext = CW'(den);

  // First stage: the quotient does not fit when the upper part reaches the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_s[0]  <= (hi_ext >= den_ext);
      rem[0]    <= hi_ext[DW-1:0];
      low[0]    <= num[QB-1:0];
      quo_s[0]  <= '0;
      side_s[0] <= side_in;
    end
  end

  // One quotient bit per stage.
  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[i], low[i][QB-1]};
    assign ge    = (trial >= {1'b0, den});
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]    <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[i+1]    <= low[i] << 1;
        quo_s[i+1]  <= {quo_s[i][QB-2:0], ge};
        ovf_s[i+1]  <= ovf_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = vld[QB];
  assign quo       = quo_s[QB];
  assign ovf       = ovf_s[QB];
  assign side_out  = side_s[QB];

endmodule

/* rtl/gm2j_hstep.sv */
// ----------------------------------------------------------------------------
// Horner step of the exponential series
// Computes p' = 1 - ((r * p) >> 30) / K in Q30 over three register stages.
// ----------------------------------------------------------------------------
module gm2j_hstep #(
  parameter int K  = 11,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [30:0]   p_in,
  input  logic [29:0]   r_in,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [30:0]   p_out,
  output logic [29:0]   r_out,
  output logic [SW-1:0] side_out
);

  localparam logic [31:0] RECIP = gm2j_pkg::recip_const(K);
  localparam logic [34:0] KV    = 35'(K);

  logic [60:0]   prod;
  logic [62:0]   mprod;
  logic [34:0]   remv;
  logic [30:0]   q;

  logic          v_a, v_b, v_c;
  logic [30:0]   w_a, w_b, q0_b, p_c;
  logic [29:0]   r_a, r_b, r_c;
  logic [SW-1:0] side_a, side_b, side_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else if (en) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
    end
  end

  // Product with the remainder of the argument reduction.
  assign prod = 61'(r_in) * 61'(p_in);

  // Division by K through the reciprocal, then one correction step.
  assign mprod = 63'(w_a) * 63'(RECIP);
  assign remv  = 35'(w_b) - 35'(q0_b) * KV;
  assign q     = (remv >= KV) ? (q0_b + 31'd1) : q0_b;

  always_ff @(posedge clk) begin
    if (en) begin
      w_a    <= prod[60:30];
      r_a    <= r_in;
      side_a <= side_in;
      w_b    <= w_a;
      q0_b   <= mprod[62:32];
      r_b    <= r_a;
      side_b <= side_a;
      p_c    <= gm2j_pkg::ONE_Q30 - q;
      r_c    <= r_b;
      side_c <= side_b;
    end
  end

  assign out_valid = v_c;
  assign p_out     = p_c;
  assign r_out     = r_c;
  assign side_out  = side_c;

endmodule

/* rtl/gm2j_exp.sv */
// ----------------------------------------------------------------------------
// Exponential unit
// Evaluates exp(-t) in Q30 for t in Q24: reduction by ln 2, an eleven-term
// Horner series and a final rounded shift by the power of two.
// ----------------------------------------------------------------------------
module gm2j_exp #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [30:0]   t_in,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [30:0]   e_out,
  output logic [SW-1:0] side_out
);

  localparam int NSTEP = 11;
  localparam int CSW   = SW + 6;

  logic [37:0]    nprod;
  logic [29:0]    r0_full;
  logic           r_ge;

  logic           v1, v2, v3, v4;
  logic           cut1, cut2, cut3;
  logic [28:0]    tt1;
  logic [5:0]     n0_1, n0_2;
  logic [24:0]    r0_2;
  logic [4:0]     n3;
  logic [23:0]    r3;
  logic [SW-1:0]  side1, side2, side3, side4;
  logic [30:0]    e4;

  logic           v_ch    [NSTEP+1];
  logic [30:0]    p_ch    [NSTEP+1];
  logic [29:0]    r_ch    [NSTEP+1];
  logic [CSW-1:0] side_ch [NSTEP+1];

  logic [SW-1:0]  side_h;
  logic [4:0]     n_h;
  logic           cut_h;
  logic [31:0]    rnd;
  logic [31:0]    sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v_ch[NSTEP];
    end
  end

  // Estimate of t / ln2 through the reciprocal; low by at most one.
  assign nprod   = 38'(t_in[28:0]) * 38'(gm2j_pkg::LN2_RECIP);
  assign r0_full = 30'(tt1) - 30'(n0_1) * 30'(gm2j_pkg::LN2_Q24);
  assign r_ge    = (r0_2 >= 25'(gm2j_pkg::LN2_Q24));

  always_ff @(posedge clk) begin
    if (en) begin
      cut1  <= (t_in >= gm2j_pkg::T_CUT);
      tt1   <= t_in[28:0];
      n0_1  <= nprod[37:32];
      side1 <= side_in;
      cut2  <= cut1;
      n0_2  <= n0_1;
      r0_2  <= r0_full[24:0];
      side2 <= side1;
      cut3  <= cut2;
      n3    <= r_ge ? 5'(n0_2 + 6'd1) : n0_2[4:0];
      r3    <= r_ge ? 24'(r0_2 - 25'(gm2j_pkg::LN2_Q24)) : r0_2[23:0];
      side3 <= side2;
    end
  end

  // Horner chain, k running from eleven down to one.
  assign v_ch[0]    = v3;
  assign p_ch[0]    = gm2j_pkg::ONE_Q30;
  assign r_ch[0]    = {r3, 6'd0};
  assign side_ch[0] = {side3, n3, cut3};

  for (genvar i = 0; i < NSTEP; i++) begin : g_horner
    gm2j_hstep #(
      .K  (NSTEP - i),
      .SW (CSW)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_ch[i]),
      .p_in      (p_ch[i]),
      .r_in      (r_ch[i]),
      .side_in   (side_ch[i]),
      .out_valid (v_ch[i+1]),
      .p_out     (p_ch[i+1]),
      .r_out     (r_ch[i+1]),
      .side_out  (side_ch[i+1])
    );
  end

  // Scale by 2^-n with rounding to nearest.
  assign {side_h, n_h, cut_h} = side_ch[NSTEP];
  assign rnd = (n_h == 5'd0) ? 32'd0 : (32'd1 << (n_h - 5'd1));
  assign sum = {1'b0, p_ch[NSTEP]} + rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      e4    <= cut_h ? 31'd0 : 31'(sum >> n_h);
      side4 <= side_h;
    end
  end

  assign out_valid = v4;
  assign e_out     = e4;
  assign side_out  = side4;

endmodule

/* test/gm2j_checker.sv */
// ----------------------------------------------------------------------------
// Gaussian 2D model and Jacobian: result checker
// Watches the configuration, sample and result channels. It keeps its own
// copy of the registers, predicts every result and compares each field.
// ----------------------------------------------------------------------------
module gm2j_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [gm2j_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic signed [31:0] model_value,
  input  logic signed [31:0] neg_d_center_x,
  input  logic signed [31:0] neg_d_center_y,
  input  logic signed [31:0] neg_d_sigma_x,
  input  logic signed [31:0] neg_d_sigma_y,
  input  logic signed [31:0] neg_d_amplitude,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = gm2j_pkg::FRAC_BITS_DEF;
  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned LN2   = 64'd11629080;
  localparam longint unsigned UCAP  = 64'd1 << 27;
  localparam longint unsigned TCUT  = 64'd22 << 24;
  localparam longint unsigned GCAP  = 64'd1 << 31;

  typedef struct packed {
    logic [31:0] model;
    logic [31:0] dcx;
    logic [31:0] dcy;
    logic [31:0] dsx;
    logic [31:0] dsy;
    logic [31:0] damp;
  } jac_row_t;

  // Shadow copy of the configuration registers.
  logic signed [31:0] cen_x, cen_y, amp, offs;
  logic [30:0]        sig_x, sig_y;

  jac_row_t row_q[$];

  // Normalised distance |d| / sigma in Q24, rounded and clamped to 8.0.
  function automatic longint unsigned norm_dist(longint unsigned mag,
                                                longint unsigned s);
    longint unsigned q;
    q = ((mag << 24) + s / 2) / s;
    return (q > UCAP) ? UCAP : q;
  endfunction

  // exp(-t) with t in Q24, result in Q30.
  function automatic longint unsigned exp_q30(longint unsigned t);
    longint unsigned n, r, p;
    if (t >= TCUT) return 0;
    n = t / LN2;
    r = (t - n * LN2) << 6;
    p = ONE30;
    for (int k = 11; k >= 1; k--) begin
      p = ONE30 - ((r * p) >> 30) / longint'(k);
    end
    if (n > 0) p = (p + (64'd1 << (n - 1))) >> n;
    return p;
  endfunction

  // |A| * g / (sigma * 2^(30-FRAC)), rounded to nearest.
  function automatic longint unsigned scaled(longint unsigned am,
                                             longint unsigned g,
                                             longint unsigned s);
    longint unsigned den;
    den = s << (30 - FRAC);
    return (am * g + den / 2) / den;
  endfunction

  // Give a magnitude its sign and clip it to the signed 32-bit range.
  function automatic logic [31:0] signed_clip(bit neg, longint unsigned mag);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(mag));
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
  endfunction

  // Expected Jacobian row for one sample point under the current registers.
  function automatic jac_row_t predict_row(logic signed [31:0] xc,
                                           logic signed [31:0] yc);
    jac_row_t r;
    longint dx, dy, a, mv;
    longint unsigned sx, sy, am, qx, qy, t, e, gx, gy, gxx, gyy, ae;
    bit an, xn, yn;
    dx = longint'(xc) - longint'(cen_x);
    dy = longint'(yc) - longint'(cen_y);
    sx = (sig_x == 0) ? 1 : longint'(sig_x);
    sy = (sig_y == 0) ? 1 : longint'(sig_y);
    a  = longint'(amp);
    an = a < 0;
    am = an ? -a : a;
    xn = dx < 0;
    yn = dy < 0;
    qx = norm_dist(xn ? -dx : dx, sx);
    qy = norm_dist(yn ? -dy : dy, sy);
    t  = (qx * qx + qy * qy + (64'd1 << 24)) >> 25;
    e  = exp_q30(t);
    gx = (e * qx) >> 24;
    gy = (e * qy) >> 24;
    if (gx > GCAP) gx = GCAP;
    if (gy > GCAP) gy = GCAP;
    gxx = (gx * qx) >> 24;
    gyy = (gy * qy) >> 24;
    if (gxx > GCAP) gxx = GCAP;
    if (gyy > GCAP) gyy = GCAP;
    ae = (am * e + (64'd1 << 29)) >> 30;
    mv = (an ? -longint'(ae) : longint'(ae)) + longint'(offs);
    if (mv > 64'sd2147483647) mv = 64'sd2147483647;
    if (mv < -64'sd2147483648) mv = -64'sd2147483648;
    r.model = 32'(mv);
    r.dcx   = signed_clip(an == xn, scaled(am, gx, sx));
    r.dcy   = signed_clip(an == yn, scaled(am, gy, sy));
    r.dsx   = signed_clip(!an, scaled(am, gxx, sx));
    r.dsy   = signed_clip(!an, scaled(am, gyy, sy));
    r.damp  = 32'(-longint'((e + (64'd1 << (29 - FRAC))) >> (30 - FRAC)));
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Track register writes, queue predictions and check every result transfer.
  always @(posedge clk) begin
    jac_row_t want;
    if (rst) begin
      cen_x <= 0;
      cen_y <= 0;
      sig_x <= 31'd1 << FRAC;
      sig_y <= 31'd1 << FRAC;
      amp   <= 32'sd1 << FRAC;
      offs  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        row_q.push_back(predict_row(x_coord, y_coord));
      end
      if (out_valid && !out_stall) begin
        if (row_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with nothing expected, actual model %h",
                   $time, model_value);
        end else begin
          want = row_q.pop_front();
          checked++;
          compare_field("model_value", want.model, model_value);
          compare_field("neg_d_center_x", want.dcx, neg_d_center_x);
          compare_field("neg_d_center_y", want.dcy, neg_d_center_y);
          compare_field("neg_d_sigma_x", want.dsx, neg_d_sigma_x);
          compare_field("neg_d_sigma_y", want.dsy, neg_d_sigma_y);
          compare_field("neg_d_amplitude", want.damp, neg_d_amplitude);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gm2j_pkg::REG_CENTER_X:  cen_x <= cfg_data;
          gm2j_pkg::REG_CENTER_Y:  cen_y <= cfg_data;
          gm2j_pkg::REG_SIGMA_X:   sig_x <= cfg_data[30:0];
          gm2j_pkg::REG_SIGMA_Y:   sig_y <= cfg_data[30:0];
          gm2j_pkg::REG_AMPLITUDE: amp   <= cfg_data;
          gm2j_pkg::REG_OFFSET:    offs  <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= row_q.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Gaussian 2D model and Jacobian: testbench top
// Drives register writes and sample points with random gaps and result-side
// stalls, then gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 120;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 300;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [gm2j_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic signed [31:0] x_coord = 0, y_coord = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic signed [31:0] model_value, neg_d_center_x, neg_d_center_y;
  logic signed [31:0] neg_d_sigma_x, neg_d_sigma_y, neg_d_amplitude;

  int  fail_count, pending, checked;
  int  points_sent = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 0;
  bit  hold_req = 0;
  logic [30:0] cur_sigma_x = 31'd1 << 16, cur_sigma_y = 31'd1 << 16;
  logic signed [31:0] cur_cx = 0, cur_cy = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  gaussian_2d_model_jacobian DUT (.*);

  gm2j_checker u_checker (.*);

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("** gaussian_2d_model_jacobian: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls per transfer, with one long hold-off on request.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 19);
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 0;
      end
      if (n > 0) begin
        out_stall = 1;
        repeat (n) @(negedge clk);
        out_stall = 0;
      end
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [gm2j_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    if (idx == gm2j_pkg::REG_SIGMA_X) cur_sigma_x = val[30:0];
    if (idx == gm2j_pkg::REG_SIGMA_Y) cur_sigma_y = val[30:0];
    if (idx == gm2j_pkg::REG_CENTER_X) cur_cx = val;
    if (idx == gm2j_pkg::REG_CENTER_Y) cur_cy = val;
  endtask

  task automatic send_point(logic [31:0] xv, logic [31:0] yv);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    x_coord  = xv;
    y_coord  = yv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    points_sent++;
  endtask

  // Wait for every expected result, then let the pipeline empty.
  task automatic drain();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // A coordinate near the centre, scaled by sigma, or now and then anything.
  function automatic logic [31:0] near_coord(logic signed [31:0] c, logic [30:0] s);
    longint span, d;
    if ($urandom_range(0, 4) == 0) return $urandom;
    span = longint'(s) * $urandom_range(1, 7);
    d = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1) - span;
    return 32'(longint'(c) + d);
  endfunction

  function automatic logic [31:0] rand_sigma();
    int sh;
    logic [31:0] v;
    sh = $urandom_range(0, 30);
    v = ($urandom & ((32'd1 << sh) - 1)) | (32'd1 << sh);
    return v;
  endfunction

  initial begin
    repeat (3) @(negedge clk);
    rst = 0;

    // Reset settings: centre, unit steps and the coordinate extremes.
    send_point(0, 0);
    send_point(32'h0001_0000, 0);
    send_point(0, 32'hFFFF_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h0003_0000, 32'h0002_0000);
    drain();

    // Zero sigma, widest sigma, most negative amplitude, saturating offset,
    // and writes to indexes beyond the register file.
    write_reg(gm2j_pkg::REG_SIGMA_X, 32'h0000_0000);
    write_reg(gm2j_pkg::REG_SIGMA_Y, 32'hFFFF_FFFF);
    write_reg(gm2j_pkg::REG_AMPLITUDE, 32'h8000_0000);
    write_reg(gm2j_pkg::REG_OFFSET, 32'h7FFF_FFFF);
    write_reg(gm2j_pkg::REG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(gm2j_pkg::REG_CENTER_Y, 32'h8000_0000);
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h7FFF_FFFE, 32'h8000_0000);
    send_point(0, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // Narrow Gaussian with the largest amplitude and lowest offset.
    write_reg(gm2j_pkg::REG_CENTER_X, 0);
    write_reg(gm2j_pkg::REG_CENTER_Y, 0);
    write_reg(gm2j_pkg::REG_SIGMA_X, 32'h0000_0100);
    write_reg(gm2j_pkg::REG_SIGMA_Y, 32'h0000_0100);
    write_reg(gm2j_pkg::REG_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(gm2j_pkg::REG_OFFSET, 32'h8000_0000);
    send_point(0, 0);
    send_point(1, 1);
    send_point(100, -100);
    send_point(-300, 256);
    send_point(32'h0000_1000, 0);
    drain();

    write_reg(gm2j_pkg::REG_SIGMA_X, 32'h4000_0000);
    write_reg(gm2j_pkg::REG_SIGMA_Y, 32'h0000_0001);
    write_reg(gm2j_pkg::REG_AMPLITUDE, 32'h0001_0000);
    write_reg(gm2j_pkg::REG_OFFSET, 0);
    send_point(32'h0010_0000, 0);
    send_point(32'h8000_0000, 2);
    drain();

    // Random phases, each under a fresh random register setting.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(gm2j_pkg::REG_CENTER_X, $urandom);
      write_reg(gm2j_pkg::REG_CENTER_Y, $urandom);
      write_reg(gm2j_pkg::REG_SIGMA_X, ($urandom_range(0, 9) == 0) ? 32'h0 : rand_sigma());
      write_reg(gm2j_pkg::REG_SIGMA_Y, rand_sigma());
      write_reg(gm2j_pkg::REG_AMPLITUDE, ($urandom_range(0, 1) == 0) ? $urandom
                : 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000));
      write_reg(gm2j_pkg::REG_OFFSET, ($urandom_range(0, 2) == 0) ? $urandom
                : 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000));
      no_gaps = (ph == 2 || ph == 5);
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < 100; i++)
        send_point(near_coord(cur_cx, cur_sigma_x), near_coord(cur_cy, cur_sigma_y));
      drain();
      no_gaps = 0;
    end

    $display("Run covered %0d sample points and %0d checked results over 11 settings,",
             points_sent, checked);
    $display("including zero and widest sigma, amplitude and offset extremes, and a long stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("** gaussian_2d_model_jacobian: PASSED **");
    end else begin
      $display("** gaussian_2d_model_jacobian: FAILED **");
    end
    $finish;
  end

endmodule
